// ----- hdl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the per-source connection throttle
// Holds the word types of both channels, the stored entry layout, the result
// of the entry evaluation unit and the operation and register codes.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 17;
  localparam int CFG_W      = 16;
  localparam int WAIT_W     = 16;
  localparam int BLK_W      = 13;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXPIRE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FLUSH  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECONDS = 2'd1;

  localparam logic [CFG_W-1:0]  LIMIT_RST = 16'd4;
  localparam logic [CFG_W-1:0]  BLOCK_RST = 16'd60;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 17'h1FFFF;
  localparam logic [WAIT_W-1:0] WAIT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] source_addr;
    logic [TIME_W-1:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic              refused;
    logic [WAIT_W-1:0] wait_seconds;
    logic              table_full;
    logic [BLK_W-1:0]  blocked_entries;
    logic [31:0]       refusal_total;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last_time;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic              match;
    logic              free;
    logic              blocked;
    logic              expired;
    logic [WAIT_W-1:0] wait_time;
  } eval_t;

endpackage

// ----- hdl/per_source_connection_throttle.sv -----
// ----------------------------------------------------------------------------
// per_source_connection_throttle: per-source connection rate limiter
// Keeps a table of IPv4 sources with last-seen time and connection count,
// walked one entry per cycle through a shared evaluation unit.
// ----------------------------------------------------------------------------
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------
//  in_      | in_valid / in_stall    | func, source_addr, now_seconds
//  out_     | out_valid / out_stall  | refused, wait_seconds, table_full,
//           |                        | blocked_entries, refusal_total
//  cfg_     | cfg_we, cfg_index      | cfg_wdata (count_limit, block_seconds)
//
// Add, query, expire and count walk the whole table through the single read
// port of the entry RAM. Flush clears every entry and unused codes go straight
// to the finish step. After reset a clearing pass over every entry runs before
// the first word is taken. One result word waits in the output register, so a
// new word is accepted while it is stalled.
// ----------------------------------------------------------------------------
module per_source_connection_throttle #(
  parameter int ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pst_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pst_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [pst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pst_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int BLK_W = pst_pkg::BLK_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_FIN} state_t;

  state_t                      state_r;
  logic [IW-1:0]               clr_r;
  logic                        clr_out_r;
  logic [IW-1:0]               scan_r;
  logic                        pend_r;
  logic [IW-1:0]               chk_idx_r;
  pst_pkg::in_word_t           op_r;
  logic [pst_pkg::CFG_W-1:0]   limit_r;
  logic [pst_pkg::CFG_W-1:0]   block_r;
  logic [31:0]                 refusal_r;
  logic [31:0]                 refusal_nxt;
  logic                        hit_r;
  logic [IW-1:0]               hit_idx_r;
  logic [pst_pkg::CNT_W-1:0]   hit_cnt_r;
  logic                        hit_blk_r;
  logic [pst_pkg::WAIT_W-1:0]  hit_wait_r;
  logic                        free_fnd_r;
  logic [IW-1:0]               free_idx_r;
  logic [CW-1:0]               blk_cnt_r;
  logic                        out_valid_r;
  pst_pkg::out_word_t          out_r;
  pst_pkg::out_word_t          out_nxt;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  pst_pkg::entry_t             ram_wdata;
  pst_pkg::entry_t             ram_rdata;
  pst_pkg::eval_t              ev;
  logic                        fin_go;
  logic                        refuse;

  pst_ram #(
    .WIDTH ($bits(pst_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  pst_eval u_eval (
    .ent   (ram_rdata),
    .addr  (op_r.source_addr),
    .now   (op_r.now_seconds),
    .limit (limit_r),
    .block (block_r),
    .res   (ev)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign fin_go    = !out_valid_r || !out_stall;
  assign refuse    = (op_r.func == pst_pkg::FN_ADD) && hit_r && hit_blk_r;
  assign refusal_nxt = refusal_r + {31'd0, refuse};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_r;
    ram_wdata = ram_rdata;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (pend_r && (op_r.func == pst_pkg::FN_EXPIRE) && ev.expired) begin
      ram_we          = 1'b1;
      ram_wdata.valid = 1'b0;
    end else if ((state_r == S_FIN) && fin_go && (op_r.func == pst_pkg::FN_ADD)) begin
      ram_wdata.valid     = 1'b1;
      ram_wdata.addr      = op_r.source_addr;
      ram_wdata.last_time = op_r.now_seconds;
      if (hit_r) begin
        ram_we          = !hit_blk_r;
        ram_waddr       = hit_idx_r;
        ram_wdata.count = (hit_cnt_r < pst_pkg::CNT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
      end else begin
        ram_we          = free_fnd_r;
        ram_waddr       = free_idx_r;
        ram_wdata.count = pst_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_nxt               = '0;
    out_nxt.refusal_total = refusal_nxt;
    unique case (op_r.func)
      pst_pkg::FN_ADD: begin
        out_nxt.refused    = refuse;
        out_nxt.table_full = !hit_r && !free_fnd_r;
      end
      pst_pkg::FN_QUERY: begin
        out_nxt.wait_seconds = (hit_r && hit_blk_r) ? hit_wait_r : '0;
      end
      pst_pkg::FN_COUNT: begin
        out_nxt.blocked_entries = BLK_W'(blk_cnt_r);
      end
      default: begin
        out_nxt.refused = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_out_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= pst_pkg::LIMIT_RST;
      block_r     <= pst_pkg::BLOCK_RST;
      refusal_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pst_pkg::REG_COUNT_LIMIT:   limit_r <= cfg_wdata;
          pst_pkg::REG_BLOCK_SECONDS: block_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      pend_r    <= (state_r == S_SCAN);
      chk_idx_r <= scan_r;
      if (pend_r) begin
        if (ev.match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= chk_idx_r;
          hit_cnt_r  <= ram_rdata.count;
          hit_blk_r  <= ev.blocked;
          hit_wait_r <= ev.wait_time;
        end
        if (ev.free && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= chk_idx_r;
        end
        if (ev.blocked) begin
          blk_cnt_r <= blk_cnt_r + 1'b1;
        end
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == LAST) begin
            clr_r     <= '0;
            clr_out_r <= 1'b0;
            state_r   <= clr_out_r ? S_FIN : S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_word;
            hit_r      <= 1'b0;
            free_fnd_r <= 1'b0;
            blk_cnt_r  <= '0;
            scan_r     <= '0;
            if (in_word.func == pst_pkg::FN_FLUSH) begin
              clr_out_r <= 1'b1;
              state_r   <= S_CLEAR;
            end else if ((in_word.func == pst_pkg::FN_ADD) ||
                         (in_word.func == pst_pkg::FN_QUERY) ||
                         (in_word.func == pst_pkg::FN_EXPIRE) ||
                         (in_word.func == pst_pkg::FN_COUNT)) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == LAST) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_r       <= out_nxt;
            refusal_r   <= refusal_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (ram_we && !ram_wdata.valid))
    else $error("clearing pass does not invalidate the entry");

  a_scan_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> pend_r)
    else $error("scan read not followed by a check");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result word loaded outside the finish step");

  a_refusal_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (refusal_r != $past(refusal_r))) |->
      (refusal_r == $past(refusal_r) + 32'd1))
    else $error("refusal counter moved by more than one");

endmodule

// ----- hdl/pst_ram.sv -----
// ----------------------------------------------------------------------------
// pst_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pst_eval.sv -----
// ----------------------------------------------------------------------------
// pst_eval: entry evaluation unit
// Compares one stored entry against the current word: address match, free
// slot, blocked state, expiry and the remaining block time.
// ----------------------------------------------------------------------------
module pst_eval (
  input  pst_pkg::entry_t                  ent,
  input  logic [pst_pkg::ADDR_W-1:0]       addr,
  input  logic [pst_pkg::TIME_W-1:0]       now,
  input  logic [pst_pkg::CFG_W-1:0]        limit,
  input  logic [pst_pkg::CFG_W-1:0]        block,
  output pst_pkg::eval_t                   res
);

  logic [pst_pkg::TIME_W:0] end_time;
  logic [pst_pkg::TIME_W:0] diff;
  logic                     later;

  assign end_time = {1'b0, ent.last_time} + {{(pst_pkg::TIME_W + 1 - pst_pkg::CFG_W){1'b0}}, block};
  assign later    = end_time > {1'b0, now};
  assign diff     = end_time - {1'b0, now};

  always_comb begin
    res.match   = ent.valid && (ent.addr == addr);
    res.free    = !ent.valid;
    res.blocked = ent.valid &&
                  (ent.count > {{(pst_pkg::CNT_W - pst_pkg::CFG_W){1'b0}}, limit});
    res.expired = ent.valid && !later;
    if (!later) begin
      res.wait_time = pst_pkg::WAIT_W'(1);
    end else if (diff[pst_pkg::TIME_W:pst_pkg::WAIT_W] != '0) begin
      res.wait_time = pst_pkg::WAIT_MAX;
    end else begin
      res.wait_time = diff[pst_pkg::WAIT_W-1:0];
    end
  end

endmodule
